// ----- sv/bfe_pkg.sv -----
// Shared types, codes and the URL-safe base64 alphabet for the frame encoder.
package bfe_pkg;

   // Item operation codes carried on req_tuser
   localparam logic [1:0] OP_RAW     = 2'd0;
   localparam logic [1:0] OP_PAYLOAD = 2'd1;
   localparam logic [1:0] OP_CLOSE   = 2'd2;

   // Framing markers and padding
   localparam logic [7:0] MARK_START = 8'h00;
   localparam logic [7:0] MARK_END   = 8'hFF;
   localparam logic [7:0] PAD_CHAR   = 8'h3D;   // '='
   localparam logic [7:0] CHAR_DASH  = 8'h2D;   // '-'
   localparam logic [7:0] CHAR_UNDER = 8'h5F;   // '_'

   // Most bytes one item can produce
   localparam int JOB_SLOTS   = 5;
   localparam int QUEUE_DEPTH = 2;

   // Work handed from the front to the back: bytes to send, in slot order
   typedef struct packed {
      logic [2:0]                count;
      logic                      error;
      logic [JOB_SLOTS-1:0][7:0] bytes;
   } job_type;

   // Map a 6-bit code to its URL-safe base64 character
   function automatic logic [7:0] url_char(input logic [5:0] code);
      logic [7:0] wide;
      wide = {2'b00, code};
      if (code < 6'd26) begin
         return wide + 8'h41;
      end else if (code < 6'd52) begin
         return wide + 8'd71;
      end else if (code < 6'd62) begin
         return wide - 8'd4;
      end else if (code == 6'd62) begin
         return CHAR_DASH;
      end else begin
         return CHAR_UNDER;
      end
   endfunction

endpackage

// ----- sv/bfe_front.sv -----
// Front end: accepts items, tracks frame state and builds the byte job for each item.
module bfe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] in_byte
   input  logic [1:0]        req_tuser,   // [1:0] operation
   input  logic              q_full,
   output logic              q_push,
   output bfe_pkg::job_type  q_job
);

   logic [15:0] pend_bytes_ff, pend_bytes_in;
   logic [1:0]  pend_count_ff, pend_count_in;
   logic        frame_open_ff, frame_open_in;
   logic        started_ff, started_in;
   logic        accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign q_push     = accept && (q_job.count != 3'd0);

   // Classify the item and lay out its result bytes
   always_comb begin
      logic [2:0]  slot;
      logic [23:0] word;
      logic [1:0]  sig;
      bfe_pkg::job_type job;
      job            = '0;
      slot           = 3'd0;
      word           = '0;
      sig            = 2'd0;
      pend_bytes_in  = pend_bytes_ff;
      pend_count_in  = pend_count_ff;
      frame_open_in  = frame_open_ff;
      started_in     = started_ff;
      case (req_tuser)
         bfe_pkg::OP_RAW: begin
            if (started_ff) begin
               // reject a raw byte once payload has begun
               job.bytes[0] = bfe_pkg::MARK_START;
               job.error    = 1'b1;
               slot         = 3'd1;
            end else begin
               if (!frame_open_ff) begin
                  job.bytes[slot] = bfe_pkg::MARK_START;
                  slot            = slot + 3'd1;
               end
               job.bytes[slot] = req_tdata;
               slot            = slot + 3'd1;
               frame_open_in   = 1'b1;
            end
         end
         bfe_pkg::OP_PAYLOAD: begin
            if (!frame_open_ff) begin
               job.bytes[slot] = bfe_pkg::MARK_START;
               slot            = slot + 3'd1;
            end
            frame_open_in = 1'b1;
            started_in    = 1'b1;
            if (pend_count_ff[1]) begin
               // third byte completes a group
               word                   = {pend_bytes_ff, req_tdata};
               job.bytes[slot]        = bfe_pkg::url_char(word[23:18]);
               job.bytes[slot + 3'd1] = bfe_pkg::url_char(word[17:12]);
               job.bytes[slot + 3'd2] = bfe_pkg::url_char(word[11:6]);
               job.bytes[slot + 3'd3] = bfe_pkg::url_char(word[5:0]);
               slot                   = slot + 3'd4;
               pend_bytes_in          = '0;
               pend_count_in          = 2'd0;
            end else if (pend_count_ff == 2'd0) begin
               pend_bytes_in = {req_tdata, 8'h00};
               pend_count_in = 2'd1;
            end else begin
               pend_bytes_in = {pend_bytes_ff[15:8], req_tdata};
               pend_count_in = 2'd2;
            end
         end
         bfe_pkg::OP_CLOSE: begin
            sig = pend_count_ff;
            if (!frame_open_ff) begin
               job.bytes[slot] = bfe_pkg::MARK_START;
               slot            = slot + 3'd1;
            end else if (sig != 2'd0) begin
               // flush the partial group with padding
               word = (sig == 2'd1) ? {pend_bytes_ff[15:8], 16'h0000}
                                    : {pend_bytes_ff, 8'h00};
               job.bytes[slot]        = bfe_pkg::url_char(word[23:18]);
               job.bytes[slot + 3'd1] = bfe_pkg::url_char(word[17:12]);
               job.bytes[slot + 3'd2] = (sig > 2'd1) ? bfe_pkg::url_char(word[11:6])
                                                     : bfe_pkg::PAD_CHAR;
               job.bytes[slot + 3'd3] = bfe_pkg::PAD_CHAR;
               slot                   = slot + 3'd4;
            end
            job.bytes[slot] = bfe_pkg::MARK_END;
            slot            = slot + 3'd1;
            pend_bytes_in   = '0;
            pend_count_in   = 2'd0;
            frame_open_in   = 1'b0;
            started_in      = 1'b0;
         end
         default: begin
            // unused code: drop the item
            slot = 3'd0;
         end
      endcase
      job.count = slot;
      q_job     = job;
   end

   // Commit frame state on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bytes_ff <= '0;
         pend_count_ff <= '0;
         frame_open_ff <= 1'b0;
         started_ff    <= 1'b0;
      end else if (accept) begin
         pend_bytes_ff <= pend_bytes_in;
         pend_count_ff <= pend_count_in;
         frame_open_ff <= frame_open_in;
         started_ff    <= started_in;
      end
   end

endmodule

// ----- sv/bfe_queue.sv -----
// Short job queue between the front and back ends.
module bfe_queue #(
   parameter int Depth = bfe_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bfe_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output bfe_pkg::job_type  pop_job
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   bfe_pkg::job_type mem_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full    = (count_ff == CW'(Depth));
   assign valid   = (count_ff != '0);
   assign pop_job = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming jobs
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Never push into a full queue or pop an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("job pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !valid)) else $error("job popped from empty queue");

endmodule

// ----- sv/bfe_back.sv -----
// Back end: walks each job byte by byte into the registered result channel.
module bfe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  bfe_pkg::job_type  q_job,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,   // last
   output logic              rsp_tuser    // [0] order_error
);

   bfe_pkg::job_type cur_ff, cur_in;
   logic [2:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;
   logic       out_free;
   logic       send;
   logic       at_end;

   assign out_free = !valid_ff || rsp_tready;
   assign send     = busy_ff && out_free;
   assign at_end   = (idx_ff == cur_ff.count - 3'd1);
   assign q_pop    = q_valid && (!busy_ff || (send && at_end));

   // Step through the current job and load the next one
   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (out_free) begin
         valid_in = 1'b0;
      end
      if (send) begin
         valid_in = 1'b1;
         data_in  = cur_ff.bytes[idx_ff];
         last_in  = at_end;
         err_in   = cur_ff.error;
         idx_in   = idx_ff + 3'd1;
         if (at_end) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         cur_in  = q_job;
         idx_in  = 3'd0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      data_ff <= data_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;

   // Active job always has a byte left to send
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_ff.count != 3'd0 && idx_ff < cur_ff.count))
      else $error("job index out of range");
   // A rejection is a lone zero byte ending its item
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && err_ff) |-> (last_ff && data_ff == bfe_pkg::MARK_START))
      else $error("malformed rejection result");

endmodule

// ----- sv/base64url_frame_encoder.sv -----
// The first result of an item passes the job queue, the current-job register and the
// result register before it shows on rsp_tvalid. Throughput: one result byte per cycle
// while rsp_tready is high, n results (1 to 5) per item; items with no result are not queued.
// The job queue (QueueDepth entries) lets the front accept while the back end drains.
// Reset (synchronous, active high) closes the frame, clears collected bytes and empties
// the queue and the result register.
module base64url_frame_encoder #(
   parameter int QueueDepth = bfe_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic [1:0] req_tuser,    // [1:0] operation
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tlast,    // last
   output logic       rsp_tuser     // [0] order_error
);

   bfe_pkg::job_type push_job;
   bfe_pkg::job_type pop_job;
   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_valid;

   bfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   bfe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_job  (pop_job)
   );

   bfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
